FILE: design/hcpe_pkg.sv
package hcpe_pkg;

	localparam int MAX_POINTS = 64;

	localparam int IDX_W      = 6;
	localparam int CNT_W      = 7;
	localparam int VEC_W      = 48;
	localparam int CRD_W      = 16;
	localparam int N_CRD      = 3;
	localparam int N_VEC      = 4;
	localparam int FRAC_W     = 16;
	localparam int T_W        = FRAC_W + 1;
	localparam int W_W        = 34;
	localparam int P_W        = W_W + CRD_W;
	localparam int OUT_W      = 24;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 96;
	localparam int CFG_IDX_W  = 3;

	localparam int DIV_BITS_PER_STAGE = 4;
	localparam int DIV_STAGES         = FRAC_W / DIV_BITS_PER_STAGE;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_POINT   = 3'd0,
		REG_END_POINT     = 3'd1,
		REG_START_TANGENT = 3'd2,
		REG_END_TANGENT   = 3'd3,
		REG_POINT_COUNT   = 3'd4
	} cfg_reg_t;

	typedef logic [VEC_W-1:0] vec_t;

	typedef struct packed {
		vec_t p0;
		vec_t p1;
		vec_t t0;
		vec_t t1;
	} vecs_t;

	typedef struct packed {
		logic           oor;
		logic [T_W-1:0] t;
	} side_t;

	typedef logic [W_W-1:0] weight_t;
	typedef weight_t [N_VEC-1:0] weights_t;

	typedef struct packed {
		logic             oor;
		logic [OUT_W-1:0] z;
		logic [OUT_W-1:0] y;
		logic [OUT_W-1:0] x;
		logic [T_W-1:0]   t;
	} item_t;

endpackage

FILE: design/hcpe_div.sv
module hcpe_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [hcpe_pkg::IDX_W-1:0]   idx,
	input  logic [hcpe_pkg::CNT_W-1:0]   point_count,
	output logic                         out_valid,
	output hcpe_pkg::side_t              out_side
);
	import hcpe_pkg::*;

	typedef struct packed {
		logic              oor;
		logic              dz;
		logic              qhi;
		logic [IDX_W-1:0]  d;
		logic [IDX_W-1:0]  rem;
		logic [FRAC_W-1:0] q;
	} div_st_t;

	// one restoring step, quotient bit shifted in at the bottom
	function automatic div_st_t div_step(div_st_t s);
		logic [IDX_W:0] r2;
		div_st_t        o;
		o  = s;
		r2 = {s.rem, 1'b0};
		if (r2 >= {1'b0, s.d}) begin
			o.rem = IDX_W'(r2 - {1'b0, s.d});
			o.q   = {s.q[FRAC_W-2:0], 1'b1};
		end else begin
			o.rem = r2[IDX_W-1:0];
			o.q   = {s.q[FRAC_W-2:0], 1'b0};
		end
		return o;
	endfunction

	logic [CNT_W-1:0] ncl;
	logic [IDX_W-1:0] dv;
	div_st_t          st_in;

	div_st_t st_s  [DIV_STAGES+1];
	logic    vld_s [DIV_STAGES+1];

	// integer part of idx/d is 0 or 1 for an index in range
	always_comb begin
		ncl       = (point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : point_count;
		dv        = IDX_W'(ncl - CNT_W'(1));
		st_in.oor = CNT_W'(idx) >= ncl;
		st_in.dz  = (dv == '0);
		st_in.qhi = (idx >= dv);
		st_in.d   = dv;
		st_in.rem = st_in.qhi ? IDX_W'(idx - dv) : idx;
		st_in.q   = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= st_in;
		end
	end

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		div_st_t nxt;

		always_comb begin
			nxt = st_s[g];
			for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
				nxt = div_step(nxt);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[g+1] <= nxt;
			end
		end
	end

	assign out_valid    = vld_s[DIV_STAGES];
	assign out_side.oor = st_s[DIV_STAGES].oor;
	// single point: t stays zero
	assign out_side.t   = st_s[DIV_STAGES].dz ? '0
		: {st_s[DIV_STAGES].qhi, st_s[DIV_STAGES].q};

endmodule

FILE: design/hcpe_basis.sv
module hcpe_basis (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  hcpe_pkg::side_t    in_side,
	output logic               out_valid,
	output hcpe_pkg::side_t    out_side,
	output hcpe_pkg::weights_t out_w
);
	import hcpe_pkg::*;

	localparam int SQ_W = 2 * T_W;
	localparam int T2_W = 2 * FRAC_W + 1;
	localparam int CU_W = T2_W + T_W;
	localparam int T3_W = 3 * FRAC_W + 1;
	localparam int A_W  = 52;

	localparam logic signed [A_W-1:0] Q48_ONE = A_W'(1) << (3 * FRAC_W);

	logic            vld_s6, vld_s7, vld_s8;
	side_t           side_s6, side_s7, side_s8;
	logic [T2_W-1:0] t2_s6, t2_s7;
	logic [T3_W-1:0] t3_s7;
	weights_t        w_s8;

	logic [SQ_W-1:0]        t_sq;
	logic [CU_W-1:0]        t_cu;
	logic signed [A_W-1:0]  a, b, c;
	logic signed [A_W-1:0]  w48 [N_VEC];

	assign t_sq = {{T_W{1'b0}}, in_side.t} * {{T_W{1'b0}}, in_side.t};
	assign t_cu = {{T_W{1'b0}}, t2_s6} * {{T2_W{1'b0}}, side_s6.t};

	// signed Q3.48 weights (52 bits), exact
	always_comb begin
		a      = $signed({{(A_W-T3_W){1'b0}}, t3_s7});
		b      = $signed({{(A_W-T2_W-FRAC_W){1'b0}}, t2_s7, {FRAC_W{1'b0}}});
		c      = $signed({{(A_W-T_W-2*FRAC_W){1'b0}}, side_s7.t, {(2*FRAC_W){1'b0}}});
		w48[0] = (a <<< 1) - (b + (b <<< 1)) + Q48_ONE;
		w48[1] = (b + (b <<< 1)) - (a <<< 1);
		w48[2] = a - (b <<< 1) + c;
		w48[3] = a - b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s6 <= in_valid;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= in_side;
			t2_s6   <= t_sq[T2_W-1:0];
			side_s7 <= side_s6;
			t2_s7   <= t2_s6;
			t3_s7   <= t_cu[T3_W-1:0];
			side_s8 <= side_s7;
			for (int j = 0; j < N_VEC; j++) begin
				// floor to signed Q1.32 (34 bits)
				w_s8[j] <= w48[j][W_W+FRAC_W-1:FRAC_W];
			end
		end
	end

	assign out_valid = vld_s8;
	assign out_side  = side_s8;
	assign out_w     = w_s8;

endmodule

FILE: design/hcpe_blend.sv
module hcpe_blend (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  hcpe_pkg::side_t    in_side,
	input  hcpe_pkg::weights_t in_w,
	input  hcpe_pkg::vecs_t    vecs,
	output logic               out_valid,
	output hcpe_pkg::item_t    out_item
);
	import hcpe_pkg::*;

	localparam int ACC_W = P_W + 2;

	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (2 * FRAC_W - 1);

	logic                  vld_s9, vld_s10;
	side_t                 side_s9;
	logic signed [P_W-1:0] prod_s9 [N_CRD][N_VEC];
	item_t                 item_s10;

	vec_t                    vsel [N_VEC];
	logic signed [ACC_W-1:0] acc  [N_CRD];
	logic [OUT_W-1:0]        crd  [N_CRD];

	assign vsel[0] = vecs.p0;
	assign vsel[1] = vecs.p1;
	assign vsel[2] = vecs.t0;
	assign vsel[3] = vecs.t1;

	// |sum| < 2^50, so the rounded signed Q19.0 value always fits in 20 bits
	always_comb begin
		for (int k = 0; k < N_CRD; k++) begin
			acc[k] = HALF;
			for (int j = 0; j < N_VEC; j++) begin
				acc[k] = acc[k] + ACC_W'(prod_s9[k][j]);
			end
			crd[k] = OUT_W'($signed(acc[k][ACC_W-1:2*FRAC_W]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s9  <= in_valid;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s9 <= in_side;
			for (int k = 0; k < N_CRD; k++) begin
				for (int j = 0; j < N_VEC; j++) begin
					prod_s9[k][j] <= $signed(in_w[j]) * $signed(vsel[j][CRD_W*k +: CRD_W]);
				end
			end
			item_s10.oor <= side_s9.oor;
			item_s10.t   <= side_s9.oor ? '0 : side_s9.t;
			item_s10.x   <= side_s9.oor ? '0 : crd[0];
			item_s10.y   <= side_s9.oor ? '0 : crd[1];
			item_s10.z   <= side_s9.oor ? '0 : crd[2];
		end
	end

	assign out_valid = vld_s10;
	assign out_item  = item_s10;

endmodule

FILE: design/hermite_curve_point_eval.sv
// Throughput: one request per cycle while the skid buffer is empty; ten
// pipeline stages (divider in five, t^2, t^3, weights, products, sums)
// then an output register.
// A one-entry skid buffer behind the output register drives s_tready.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the
// registers with zero vectors and a point count of 20.
module hermite_curve_point_eval (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [hcpe_pkg::IN_DATA_W-1:0]    s_tdata,   // sample_index
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [hcpe_pkg::OUT_DATA_W-1:0]   m_tdata,   // param_t, point_x, point_y, point_z
	output logic                              m_tuser,   // out_of_range
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hcpe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hcpe_pkg::VEC_W-1:0]        cfg_data
);
	import hcpe_pkg::*;

	vecs_t            vecs_q;
	logic [CNT_W-1:0] point_count_q;

	logic     en;
	logic     div_vld, bas_vld, bl_vld;
	side_t    div_side, bas_side;
	weights_t bas_w;
	item_t    bl_item;

	logic  out_vld_q, skid_vld_q;
	item_t out_q, skid_q;
	logic  take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vecs_q        <= '0;
			point_count_q <= CNT_W'(20);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_START_POINT:   vecs_q.p0     <= cfg_data;
				REG_END_POINT:     vecs_q.p1     <= cfg_data;
				REG_START_TANGENT: vecs_q.t0     <= cfg_data;
				REG_END_TANGENT:   vecs_q.t1     <= cfg_data;
				REG_POINT_COUNT:   point_count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign en       = !skid_vld_q;
	assign s_tready = en;

	hcpe_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (s_tvalid),
		.idx         (s_tdata[IDX_W-1:0]),
		.point_count (point_count_q),
		.out_valid   (div_vld),
		.out_side    (div_side)
	);

	hcpe_basis u_basis (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_vld),
		.in_side   (div_side),
		.out_valid (bas_vld),
		.out_side  (bas_side),
		.out_w     (bas_w)
	);

	hcpe_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (bas_vld),
		.in_side   (bas_side),
		.in_w      (bas_w),
		.vecs      (vecs_q),
		.out_valid (bl_vld),
		.out_item  (bl_item)
	);

	assign take = out_vld_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (bl_vld) begin
			if (out_vld_q && !take) begin
				skid_vld_q <= 1'b1;
			end
			out_vld_q <= 1'b1;
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (bl_vld) begin
			if (out_vld_q && !take) begin
				skid_q <= bl_item;
			end else begin
				out_q <= bl_item;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_DATA_W'({out_q.z, out_q.y, out_q.x, out_q.t});
	assign m_tuser  = out_q.oor;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry held while output register empty");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("out-of-range result carries non-zero data");

	a_t_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[T_W-1:0] <= T_W'(65536)))
		else $error("param_t above one");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && !take) |=> (skid_vld_q && $stable(skid_q)))
		else $error("stalled skid entry lost or changed");

endmodule
